FILE: src/mbd_pkg.sv
// Shared types and constants of the 2x2 box-filter mipmap downsampler.
// Used by every module of the block; depends on nothing.
package mbd_pkg;

   localparam int MAX_SRC_WIDTH  = 4096;
   localparam int MAX_SRC_HEIGHT = 4096;

   localparam int DIM_W     = $clog2(MAX_SRC_WIDTH) + 1;   // holds the width itself
   localparam int DIMH_W    = $clog2(MAX_SRC_HEIGHT) + 1;
   localparam int COL_CNT_W = $clog2(MAX_SRC_WIDTH);
   localparam int ROW_CNT_W = $clog2(MAX_SRC_HEIGHT);
   localparam int LINE_DEPTH = MAX_SRC_WIDTH / 2;
   localparam int LINE_COL_W = $clog2(LINE_DEPTH);

   localparam int NUM_CH  = 4;
   localparam int CH_W    = 8;
   localparam int SUM_W   = CH_W + 1;
   localparam int PIXEL_W = NUM_CH * CH_W;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = (DIM_W > DIMH_W) ? DIM_W : DIMH_W;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_SRC_HEIGHT = 1'b1;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef logic [NUM_CH-1:0][CH_W-1:0]  pixel_type;
   typedef logic [NUM_CH-1:0][SUM_W-1:0] pair_sums_type;

   typedef enum logic {
      CMD_STORE,
      CMD_EMIT
   } cmd_kind_type;

   // One horizontal pair, handed from the front end to the line-store back end.
   typedef struct packed {
      cmd_kind_type              kind;
      logic [LINE_COL_W-1:0]     col;
      pair_sums_type             sums;
      logic                      last;
   } cmd_type;

endpackage

FILE: src/mbd_front.sv
// Front end: configuration registers, frame position counters and horizontal pair sums.
// Depends on mbd_pkg; feeds pair commands into mbd_fifo.
module mbd_front
   import mbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,
   output logic                  push,
   output cmd_type               push_cmd,
   input  logic                  queue_full
);

   logic [DIM_W-1:0]     width_ff, width_in;
   logic [DIMH_W-1:0]    height_ff, height_in;
   logic [COL_CNT_W-1:0] col_ff, col_in;
   logic [ROW_CNT_W-1:0] row_ff, row_in;
   pixel_type            partial_ff, partial_in;
   pixel_type            pixel;
   logic                 accept;
   logic [DIM_W-1:0]     col_next;
   logic [DIMH_W-1:0]    row_next;
   logic [DIM_W-2:0]     half_w_m1;
   logic [DIMH_W-2:0]    half_h_m1;
   logic [DIM_W-1:0]     w_clamped;
   logic [DIMH_W-1:0]    h_clamped;

   assign pixel      = pixel_type'(req_tdata);
   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   // Out-of-range writes saturate to the legal span.
   always_comb begin
      if (csr_wdata[DIM_W-1:0] < DIM_W'(2)) begin
         w_clamped = DIM_W'(2);
      end else if (csr_wdata[DIM_W-1:0] > DIM_W'(MAX_SRC_WIDTH)) begin
         w_clamped = DIM_W'(MAX_SRC_WIDTH);
      end else begin
         w_clamped = csr_wdata[DIM_W-1:0];
      end
      if (csr_wdata[DIMH_W-1:0] < DIMH_W'(2)) begin
         h_clamped = DIMH_W'(2);
      end else if (csr_wdata[DIMH_W-1:0] > DIMH_W'(MAX_SRC_HEIGHT)) begin
         h_clamped = DIMH_W'(MAX_SRC_HEIGHT);
      end else begin
         h_clamped = csr_wdata[DIMH_W-1:0];
      end
   end

   assign col_next = DIM_W'(col_ff) + DIM_W'(1);
   assign row_next = DIMH_W'(row_ff) + DIMH_W'(1);

   always_comb begin
      width_in   = width_ff;
      height_in  = height_ff;
      col_in     = col_ff;
      row_in     = row_ff;
      partial_in = partial_ff;
      if (csr_wr_en) begin
         // Any write restarts the frame.
         if (csr_index == CSR_SRC_WIDTH) begin
            width_in = w_clamped;
         end
         if (csr_index == CSR_SRC_HEIGHT) begin
            height_in = h_clamped;
         end
         col_in = '0;
         row_in = '0;
      end else if (accept) begin
         if (!col_ff[0]) begin
            partial_in = pixel;
         end
         if (col_next >= width_ff) begin
            col_in = '0;
            if (row_next >= height_ff) begin
               row_in = '0;
            end else begin
               row_in = row_next[ROW_CNT_W-1:0];
            end
         end else begin
            col_in = col_next[COL_CNT_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_W'(2);
         height_ff <= DIMH_W'(2);
         col_ff    <= '0;
         row_ff    <= '0;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         col_ff    <= col_in;
         row_ff    <= row_in;
      end
   end

   always_ff @(posedge clock) begin
      partial_ff <= partial_in;
   end

   assign half_w_m1 = width_ff[DIM_W-1:1] - (DIM_W-1)'(1);
   assign half_h_m1 = height_ff[DIMH_W-1:1] - (DIMH_W-1)'(1);

   // The second pixel of a pair closes it and becomes a command.
   assign push = accept && col_ff[0];

   always_comb begin
      push_cmd.kind = row_ff[0] ? CMD_EMIT : CMD_STORE;
      push_cmd.col  = col_ff[COL_CNT_W-1:1];
      for (int c = 0; c < NUM_CH; c++) begin
         push_cmd.sums[c] = SUM_W'(partial_ff[c]) + SUM_W'(pixel[c]);
      end
      push_cmd.last = (half_w_m1 == (DIM_W-1)'(col_ff[COL_CNT_W-1:1]))
                   && (half_h_m1 == (DIMH_W-1)'(row_ff[ROW_CNT_W-1:1]));
   end

endmodule

FILE: src/mbd_fifo.sv
// Short command queue between the front end and the line-store back end.
// Depends on mbd_pkg for the command type and the queue depth.
module mbd_fifo
   import mbd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_cmd,
   input  logic    pop,
   output cmd_type head,
   output logic    not_empty,
   output logic    full
);

   localparam logic [QPTR_W:0] DEPTH_CNT = (QPTR_W+1)'(QUEUE_DEPTH);

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;

   assign head      = entry_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == DEPTH_CNT);

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (QPTR_W+1)'(1);
         2'b01:   count_in = count_ff - (QPTR_W+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: src/mbd_back.sv
// Back end: pair-sum line store, vertical add and the output register.
// Depends on mbd_pkg; drains commands from mbd_fifo.
module mbd_back
   import mbd_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               cmd_valid,
   input  cmd_type            cmd,
   output logic               pop,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [PIXEL_W-1:0] rsp_tdata,
   output logic               rsp_tlast
);

   pair_sums_type line_mem [LINE_DEPTH];

   pair_sums_type above_ff;
   pair_sums_type s1_sums_ff;
   logic          s1_last_ff;
   logic          s1_valid_ff, s1_valid_in;
   logic          rsp_valid_ff, rsp_valid_in;
   pixel_type     rsp_data_ff, avg;
   logic          rsp_last_ff;
   logic          out_ready, s1_free, pop_emit, pop_store;
   logic [SUM_W:0] total [NUM_CH];

   assign out_ready = !rsp_valid_ff || rsp_tready;
   assign s1_free   = !s1_valid_ff || out_ready;

   // Stores never wait; a block result waits for room in the read stage.
   assign pop       = cmd_valid && ((cmd.kind == CMD_STORE) || s1_free);
   assign pop_store = pop && (cmd.kind == CMD_STORE);
   assign pop_emit  = pop && (cmd.kind == CMD_EMIT);

   always_ff @(posedge clock) begin
      if (pop_store) begin
         line_mem[cmd.col] <= cmd.sums;
      end
      if (pop_emit) begin
         above_ff <= line_mem[cmd.col];
      end
   end

   always_ff @(posedge clock) begin
      if (pop_emit) begin
         s1_sums_ff <= cmd.sums;
         s1_last_ff <= cmd.last;
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         total[c] = (SUM_W+1)'(s1_sums_ff[c]) + (SUM_W+1)'(above_ff[c]);
         avg[c]   = total[c][SUM_W:2];
      end
   end

   always_comb begin
      if (pop_emit) begin
         s1_valid_in = 1'b1;
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end else begin
         s1_valid_in = s1_valid_ff;
      end
      rsp_valid_in = out_ready ? s1_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && s1_valid_ff) begin
         rsp_data_ff <= avg;
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = PIXEL_W'(rsp_data_ff);
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: src/mipmap_box_downsample_2x2.sv
// Top level of the 2x2 box-filter mipmap downsampler for RGBA8 pixels.
// Depends on mbd_pkg, mbd_front, mbd_fifo and mbd_back.
//
// Usage: source pixels arrive on the req_ stream in raster order, one word per
// pixel. Every 2x2 block of the source frame gives one word on the rsp_ stream:
// the per-channel mean of its four pixels, truncated. The word that closes the
// frame carries rsp_tlast. An odd last column or row is consumed without result.
// The csr_ port sets the source width and height (clamped to 2..4096); any
// write restarts the frame at its first pixel. Write it only while the block
// is idle.
// Throughput: one pixel per clock while the queue has room, for every frame size.
// The pair that completes a block passes through the queue, then the registered
// line-store read, then the vertical add into the output register.
// Reset clears the position, the queue and the pipeline valids, and sets the
// frame to 2x2. The line store is not cleared; every entry is written on an
// even row before the odd row below reads it.
// When the receiver stalls, the result word holds, the queue between front end
// and back end fills, and req_tready drops once the queue is full.
module mipmap_box_downsample_2x2
   import mbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // Configuration write port.
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   // Source pixel stream.
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,   // in_red, in_green, in_blue, in_alpha
   // Downsampled pixel stream.
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [PIXEL_W-1:0]    rsp_tdata,   // avg_red, avg_green, avg_blue, avg_alpha
   output logic                  rsp_tlast    // frame_done
);

   logic    push;
   cmd_type push_cmd;
   logic    pop;
   cmd_type head;
   logic    not_empty;
   logic    full;

   // The front end tracks the frame position and forms horizontal pair sums.
   mbd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .push_cmd   (push_cmd),
      .queue_full (full)
   );

   // The queue lets a stalled output back up without losing pairs in flight.
   mbd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_cmd  (push_cmd),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (full)
   );

   // The back end stores even-row pairs and combines odd-row pairs with them.
   mbd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cmd_valid  (not_empty),
      .cmd        (head),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

FILE: src/mbd_checker.sv
// Port-level checks of the 2x2 mipmap downsampler, bound to its top level.
// Depends on mbd_pkg for port widths.
module mbd_checker
   import mbd_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  req_tready,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [PIXEL_W-1:0]    rsp_tdata,
   input logic                  rsp_tlast
);

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("rsp word changed while stalled");

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Reset empties the queue, so the source side is open right after it.
   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("req_tready low after reset");

endmodule

bind mipmap_box_downsample_2x2 mbd_checker u_mbd_checker (.*);

FILE: dv/mbd_mean_checker.sv
// Checker for the 2x2 box-filter mipmap downsampler: tracks the frame position, predicts each
// block mean and compares the result words in order. Depends on mbd_pkg only.
module mbd_mean_checker
   import mbd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [PIXEL_W-1:0]    req_tdata,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [PIXEL_W-1:0]    rsp_tdata,
   input  logic                  rsp_tlast,
   output int                    mismatch_count,
   output int                    pending_means
);

   typedef struct packed {
      pixel_type mean;
      logic      frame_done;
   } block_mean_type;

   localparam int REPORT_CAP = 40;

   string          channel_name [NUM_CH] = '{"avg_red", "avg_green", "avg_blue", "avg_alpha"};
   block_mean_type expected_means [$];
   pair_sums_type  upper_pairs [LINE_DEPTH];
   pixel_type      held_pixel;
   int             frame_w, frame_h;
   int             col_pos, row_pos;
   int             reports;

   function automatic int clamp_dim(input logic [CSR_DATA_W-1:0] raw, input int dim_max);
      if (raw < 2)
         return 2;
      if (raw > dim_max)
         return dim_max;
      return int'(raw);
   endfunction

   always @(posedge clock) begin : track
      int             blk;
      logic [SUM_W:0] total;
      pair_sums_type  pair_sum;
      pixel_type      px;
      pixel_type      got_mean;
      block_mean_type want;
      if (reset) begin
         frame_w        = 2;
         frame_h        = 2;
         col_pos        = 0;
         row_pos        = 0;
         held_pixel     = '0;
         mismatch_count = 0;
         reports        = 0;
         expected_means.delete();
      end else begin
         // Results are checked before the new pixel is predicted; no result can stem from
         // a pixel taken at the same edge.
         if (rsp_tvalid && rsp_tready) begin
            got_mean = rsp_tdata;
            if (expected_means.size() == 0) begin
               mismatch_count++;
               if (reports < REPORT_CAP) begin
                  $display("%0t: unexpected result word %h last %b, nothing predicted",
                           $time, rsp_tdata, rsp_tlast);
                  reports++;
               end
            end else begin
               want = expected_means.pop_front();
               for (int c = 0; c < NUM_CH; c++) begin
                  if (got_mean[c] !== want.mean[c]) begin
                     mismatch_count++;
                     if (reports < REPORT_CAP) begin
                        $display("%0t: %s expected %0d actual %0d", $time,
                                 channel_name[c], want.mean[c], got_mean[c]);
                        reports++;
                     end
                  end
               end
               if (rsp_tlast !== want.frame_done) begin
                  mismatch_count++;
                  if (reports < REPORT_CAP) begin
                     $display("%0t: frame_done expected %b actual %b", $time,
                              want.frame_done, rsp_tlast);
                     reports++;
                  end
               end
            end
         end

         // Any register write restarts the frame at its first pixel.
         if (csr_wr_en) begin
            if (csr_index == CSR_SRC_WIDTH)
               frame_w = clamp_dim(csr_wdata, MAX_SRC_WIDTH);
            else if (csr_index == CSR_SRC_HEIGHT)
               frame_h = clamp_dim(csr_wdata, MAX_SRC_HEIGHT);
            col_pos = 0;
            row_pos = 0;
         end

         if (req_tvalid && req_tready) begin
            px = req_tdata;
            if (col_pos % 2 == 0) begin
               held_pixel = px;
            end else begin
               blk = col_pos / 2;
               for (int c = 0; c < NUM_CH; c++)
                  pair_sum[c] = {1'b0, held_pixel[c]} + {1'b0, px[c]};
               if (row_pos % 2 == 0) begin
                  upper_pairs[blk] = pair_sum;
               end else begin
                  for (int c = 0; c < NUM_CH; c++) begin
                     total = {1'b0, pair_sum[c]} + {1'b0, upper_pairs[blk][c]};
                     want.mean[c] = total[SUM_W:2];
                  end
                  want.frame_done = (blk == frame_w / 2 - 1) &&
                                    (row_pos / 2 == frame_h / 2 - 1);
                  expected_means.push_back(want);
               end
            end
            col_pos++;
            if (col_pos >= frame_w) begin
               col_pos = 0;
               row_pos++;
               if (row_pos >= frame_h)
                  row_pos = 0;
            end
         end
      end
      pending_means <= expected_means.size();
   end

endmodule

FILE: dv/tb_mipmap_box_downsample_2x2.sv
// Testbench top for the 2x2 box-filter mipmap downsampler: drives pixel frames of many sizes
// and the frame-size registers, and gives the verdict. Depends on mbd_pkg, the block and
// mbd_mean_checker.
module tb_mipmap_box_downsample_2x2;
   import mbd_pkg::*;

   // Timeout for the whole run, set far above the length of the slowest correct run.
   localparam longint TIMEOUT      = 15_000_000;
   localparam int     RANDOM_ITEMS = 850;
   localparam int     HOLD_CYCLES  = 300;
   // Store-only pairs may still sit in the queue and the back end once the last result has
   // left; this many cycles lets them drain before a register write.
   localparam int     SETTLE       = 12;

   logic                  clock;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [PIXEL_W-1:0]    req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [PIXEL_W-1:0]    rsp_tdata;
   logic                  rsp_tlast;

   int mismatch_count;
   int pending_means;

   // Idling percentages for the two sides; the stimulus changes them as the run moves on.
   int sender_idle_pct;
   int receiver_idle_pct;
   // Each increment asks the receiver process for one long hold-off.
   int hold_serial;

   // Frame size the stimulus plans with, and stimulus bookkeeping.
   int cur_w, cur_h;
   int random_pixels;
   int phase_no;

   mipmap_box_downsample_2x2 dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   mbd_mean_checker mean_check (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pending_means  (pending_means)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #(TIMEOUT);
      $display("Mismatches found");
      $finish;
   end

   // Receiver side. It normally idles at random; when a hold-off is requested it keeps
   // rsp_tready low for a long stretch, counted here, so that the queue inside the block
   // fills up and req_tready drops while the sender keeps offering words.
   initial begin : receiver
      int seen_serial;
      int hold_left;
      seen_serial = 0;
      hold_left   = 0;
      rsp_tready  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_serial != seen_serial) begin
            seen_serial = hold_serial;
            hold_left   = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
         end
      end
   end

   // Random pixel, biased now and then toward all-ones and all-zeros so that the channel
   // sums reach both ends of their range.
   function automatic pixel_type random_pixel();
      case ($urandom_range(9))
         0:       return '1;
         1:       return '0;
         default: return $urandom;
      endcase
   endfunction

   // Offers one word and returns at the edge that takes it. tvalid stays high on return,
   // so back-to-back words are not interrupted; idle gaps are inserted before the word.
   task automatic send_pixel(input pixel_type px);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= px;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   // Stops sending and waits until every predicted result word has been taken, then lets
   // store-only pairs drain. The first edge lets the checker count the last word sent.
   task automatic wait_for_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_means != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Writes the chosen frame-size registers while the block is idle. csr_wr_en stays high
   // across two back-to-back writes and is lowered once after the last one.
   task automatic set_frame(input bit do_w, input int w, input bit do_h, input int h);
      wait_for_idle();
      if (do_w) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_SRC_WIDTH;
         csr_wdata <= CSR_DATA_W'(w);
         @(posedge clock);
      end
      if (do_h) begin
         csr_wr_en <= 1'b1;
         csr_index <= CSR_SRC_HEIGHT;
         csr_wdata <= CSR_DATA_W'(h);
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   // A large frame, with raw register values that may lie outside the legal range. Only a
   // short stretch of it is sent, and those words count toward the random item budget.
   task automatic run_big(input int w, input int h, input int n);
      set_frame(1'b1, w, 1'b1, h);
      for (int i = 0; i < n; i++)
         send_pixel(random_pixel());
      random_pixels += n;
      cur_w = MAX_SRC_WIDTH;
      cur_h = MAX_SRC_HEIGHT;
   endtask

   // One small phase: a new frame size, one to three whole frames, sometimes a trailing
   // partial frame that the next register write cuts off, and sometimes a pause in the
   // middle until every result has come back.
   task automatic run_small(input bit force_hold);
      int  pattern, w, h, w_raw, h_raw, n, pause_at;
      bit  do_w, do_h;
      pattern = $urandom_range(3);
      w = ($urandom_range(7) == 0) ? $urandom_range(11, 64) : $urandom_range(2, 10);
      h = ($urandom_range(9) == 0) ? $urandom_range(7, 8) : $urandom_range(2, 6);
      if (force_hold) begin
         w       = 16;
         h       = 8;
         pattern = 2;
      end
      do_w = (pattern != 1) || (cur_w > 64);
      do_h = (pattern != 0) || (cur_h > 8);
      // A legal size of 2 is sometimes written as 0 or 1, which the block raises to 2.
      w_raw = (w == 2 && $urandom_range(1) == 1) ? $urandom_range(1) : w;
      h_raw = (h == 2 && $urandom_range(1) == 1) ? $urandom_range(1) : h;
      set_frame(do_w, w_raw, do_h, h_raw);
      if (do_w)
         cur_w = w;
      if (do_h)
         cur_h = h;
      n = (force_hold ? 2 : $urandom_range(1, 3)) * cur_w * cur_h;
      if ($urandom_range(3) == 0)
         n += $urandom_range(1, cur_w * cur_h - 1);
      pause_at = ($urandom_range(3) == 0) ? n / 2 : -1;
      if (force_hold || $urandom_range(5) == 0)
         hold_serial <= hold_serial + 1;
      for (int i = 0; i < n; i++) begin
         if (i == pause_at)
            wait_for_idle();
         send_pixel(random_pixel());
      end
      random_pixels += n;
   endtask

   initial begin
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_index         = CSR_SRC_WIDTH;
      csr_wdata         = '0;
      req_tvalid        = 1'b0;
      req_tdata         = '0;
      hold_serial       = 0;
      sender_idle_pct   = 33;
      receiver_idle_pct = 56;
      cur_w             = 2;
      cur_h             = 2;
      random_pixels     = 0;
      phase_no          = 0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset frame size of 2x2 first: all-ones and all-zeros blocks
      // give the extreme means, then a block whose channel sums each need truncation.
      // Pixels are written as {alpha, blue, green, red}.
      repeat (4) send_pixel('1);
      repeat (4) send_pixel('0);
      send_pixel(32'h80_01_00_FF);
      send_pixel(32'h7F_02_00_FF);
      send_pixel(32'h80_03_00_FF);
      send_pixel(32'h80_04_03_FE);
      // Odd width and odd height: the last column and the last row give no result.
      set_frame(1'b1, 3, 1'b1, 3);
      cur_w = 3;
      cur_h = 3;
      repeat (9) send_pixel(random_pixel());

      // Random part. The first third idles the sender lightly and the receiver heavily,
      // the second third the other way round, the last third not at all. A few large
      // frames, including clamped register values and the largest sizes, are mixed in.
      while (random_pixels < RANDOM_ITEMS || phase_no <= 11) begin
         if (random_pixels < RANDOM_ITEMS / 3) begin
            sender_idle_pct   = 33;
            receiver_idle_pct = 56;
         end else if (random_pixels < 2 * RANDOM_ITEMS / 3) begin
            sender_idle_pct   = 56;
            receiver_idle_pct = 33;
         end else begin
            sender_idle_pct   = 0;
            receiver_idle_pct = 0;
         end
         case (phase_no)
            2:       run_big(MAX_SRC_WIDTH + 1, 0, 24);
            5:       run_big(MAX_SRC_WIDTH - 1, 3, 24);
            // Width raised to 2 and height lowered to the largest: one result per block,
            // none of them closing the frame.
            8:       run_big(1, (1 << CSR_DATA_W) - 1, 64);
            // Largest legal sizes written exactly; part of the first row, then cut off.
            11:      run_big(MAX_SRC_WIDTH, MAX_SRC_HEIGHT, 24);
            default: run_small(phase_no == 0);
         endcase
         phase_no++;
      end

      // Drain: every predicted word must arrive, then a quiet stretch catches extra words.
      wait_for_idle();
      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_means == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

FILE: sim.f
src/mbd_pkg.sv
src/mbd_front.sv
src/mbd_fifo.sv
src/mbd_back.sv
src/mipmap_box_downsample_2x2.sv
src/mbd_checker.sv
dv/mbd_mean_checker.sv
dv/tb_mipmap_box_downsample_2x2.sv
